// ----- hdl/ofs_pkg.sv -----
// ----------------------------------------------------------------------------
// ofs_pkg: shared types and constants of the obstacle flag stencil
// Field widths, register indexes, reset values and the stencil bit group.
// ----------------------------------------------------------------------------
`default_nettype none

package ofs_pkg;

  // field widths fixed by the interface
  localparam int GREY_W    = 8;
  localparam int SIZE_W    = 11;
  localparam int FLAGS_W   = 5;
  localparam int CFG_IDX_W = 2;

  // default bounds of the frame interior
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // register reset values
  localparam logic [GREY_W-1:0] THRESHOLD_RST = GREY_W'(100);
  localparam logic [SIZE_W-1:0] WIDTH_RST     = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] HEIGHT_RST    = SIZE_W'(1024);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

  // cross stencil around one interior cell
  typedef struct packed {
    logic center;
    logic east;
    logic west;
    logic south;
    logic north;
  } ofs_stencil_t;

endpackage

`default_nettype wire

// ----- hdl/ofs_ram.sv -----
// ----------------------------------------------------------------------------
// ofs_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered under read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module ofs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1026,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hdl/ofs_flag_logic.sv -----
// ----------------------------------------------------------------------------
// ofs_flag_logic: cell flag word and forbidden-pattern check
// Packs the cross stencil into the flag word and tests opposing pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module ofs_flag_logic
  import ofs_pkg::*;
(
  input  wire ofs_stencil_t        stencil,
  output logic [FLAGS_W-1:0]       cell_flags,
  output logic                     forbidden
);

  logic ew_solid, ns_solid, ew_fluid, ns_fluid;

  assign cell_flags = stencil;  // center, east, west, south, north from msb down

  assign ew_solid = !stencil.east && !stencil.west;
  assign ns_solid = !stencil.north && !stencil.south;
  assign ew_fluid = stencil.east && stencil.west;
  assign ns_fluid = stencil.north && stencil.south;

  // fluid cell pinched between solids, or solid cell pinched between fluid
  assign forbidden = stencil.center ? (ew_solid || ns_solid) : (ew_fluid || ns_fluid);

endmodule

`default_nettype wire

// ----- hdl/obstacle_flag_stencil_unit.sv -----
// ----------------------------------------------------------------------------
// obstacle_flag_stencil_unit: streaming cell flags from a thresholded frame
// Output: a result word is registered and valid in the cycle after its pixel.
// Throughput: one pixel per cycle while the output has room; each line store
//   RAM takes one write and one read per cycle, which sets that rate. Input is
//   also held after a configuration write while the middle store is read again.
// Reset: counters to the frame origin, registers to defaults, output empty.
//   Line stores are not cleared; rows 0 and 1 of a frame refill them.
// ----------------------------------------------------------------------------
`default_nettype none

module obstacle_flag_stencil_unit
  import ofs_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // pixel input
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [GREY_W-1:0]    in_grey_level,
  // result output
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [FLAGS_W-1:0]        out_cell_flags,
  output logic                      out_forbidden,
  output logic [SIZE_W-1:0]         out_cell_col,
  output logic [SIZE_W-1:0]         out_cell_row,
  output logic                      out_last_cell,
  // configuration write
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]    cfg_data
);

  // Store depth covers the boundary ring on both sides of a row.
  localparam int DEPTH = MAX_WIDTH + 2;
  localparam int COL_W = $clog2(MAX_WIDTH + 2);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

  // --------------------------------------------------------------------------
  // Configuration registers: always ready, write by index, drop unknown ones
  // --------------------------------------------------------------------------
  logic [GREY_W-1:0] thresh_r;
  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic              refetch_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESHOLD_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_THRESHOLD: thresh_r <= cfg_data[GREY_W-1:0];
        CFG_WIDTH:     width_r  <= cfg_data;
        CFG_HEIGHT:    height_r <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Hold the input in the cycle after a write so that the middle store read
  // can follow a new width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refetch_r <= 1'b0;
    end else begin
      refetch_r <= cfg_valid && cfg_ready;
    end
  end

  // Clamp sizes into 1..MAX; zero behaves as one.
  logic [COL_W-1:0] w_eff, w_p1;
  logic [ROW_W-1:0] h_eff, h_p1;

  always_comb begin
    if (width_r == '0) begin
      w_eff = COL_W'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = COL_W'(width_r);
    end
    if (height_r == '0) begin
      h_eff = ROW_W'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_W'(height_r);
    end
  end

  assign w_p1 = w_eff + 1'b1;
  assign h_p1 = h_eff + 1'b1;

  // --------------------------------------------------------------------------
  // Raster position of the next pixel
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             row_end;
  logic             emit;
  logic             in_acc;

  assign row_end = (col_r >= w_p1);
  // The pixel completes interior cell (col, row-1) from row 2 onwards.
  assign emit = (row_r >= ROW_W'(2)) && (row_r <= h_p1) &&
                (col_r >= COL_W'(1)) && (col_r <= w_eff);

  // Hold the pixel only when it brings a result and the output is still full,
  // or while the middle store is being read again after a write.
  assign in_ready = !refetch_r && (!out_valid || out_ready || !emit);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    col_nxt = col_r + 1'b1;
    row_nxt = row_r;
    if (row_end) begin
      col_nxt = '0;
      row_nxt = (row_r >= h_p1) ? '0 : row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Line stores. Each RAM is read one pixel ahead so that its registered data
  // is waiting when the pixel arrives.
  //   older store : read at the next pixel's column (south neighbour)
  //   middle store: read at the next pixel's east column; at the end of a row
  //                 fetch column 0 instead, as it becomes the next centre.
  //                 While no pixel is taken, read again at the waiting pixel's
  //                 east column so that a width written mid-frame is followed.
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] mid_raddr;
  logic [COL_W-1:0] mid_raddr_hold;
  logic             mid_rdata, old_rdata;
  logic             fluid;
  logic             cen_r;    // middle row at the current column
  logic             west_r;   // middle row at the previous column

  assign fluid          = (in_grey_level > thresh_r);
  assign mid_raddr      = (col_nxt == w_p1) ? '0 : col_nxt + 1'b1;
  assign mid_raddr_hold = (col_r >= w_p1) ? '0 : col_r + 1'b1;

  ofs_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_older_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (col_r),
    .wdata (cen_r),
    .re    (in_acc),
    .raddr (col_nxt),
    .rdata (old_rdata)
  );

  ofs_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_middle_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (col_r),
    .wdata (fluid),
    .re    (1'b1),
    .raddr (in_acc ? mid_raddr : mid_raddr_hold),
    .rdata (mid_rdata)
  );

  // Advance the centre and west taps along the middle row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_r  <= 1'b0;
      west_r <= 1'b0;
    end else if (in_acc) begin
      cen_r  <= mid_rdata;
      west_r <= cen_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stencil evaluation
  // --------------------------------------------------------------------------
  ofs_stencil_t     stencil;
  logic [FLAGS_W-1:0] flags;
  logic             bad;

  assign stencil.center = cen_r;
  assign stencil.east   = mid_rdata;
  assign stencil.west   = west_r;
  assign stencil.south  = old_rdata;
  assign stencil.north  = fluid;

  ofs_flag_logic u_flag_logic (
    .stencil    (stencil),
    .cell_flags (flags),
    .forbidden  (bad)
  );

  // --------------------------------------------------------------------------
  // Result register: load on an emitting pixel, drop once taken
  // --------------------------------------------------------------------------
  logic               out_valid_r;
  logic [FLAGS_W-1:0] flags_r;
  logic               bad_r;
  logic [SIZE_W-1:0]  cell_col_r;
  logic [SIZE_W-1:0]  cell_row_r;
  logic               last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      flags_r    <= flags;
      bad_r      <= bad;
      cell_col_r <= SIZE_W'(col_r);
      cell_row_r <= SIZE_W'(row_r - 1'b1);
      last_r     <= (col_r == w_eff) && (row_r == h_p1);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_flags = flags_r;
  assign out_forbidden  = bad_r;
  assign out_cell_col   = cell_col_r;
  assign out_cell_row   = cell_row_r;
  assign out_last_cell  = last_r;

endmodule

`default_nettype wire

// ----- dv/tb_obstacle_flag_stencil_unit.sv -----
// ----------------------------------------------------------------------------
// tb_obstacle_flag_stencil_unit: self-checking bench of the stencil flag unit
// Streams grey frames through the unit and predicts every cell word from its
// own copy of the line stores, raster position and registers. Each accepted
// result word is checked field by field, in order, against the oldest
// prediction. Both sides idle at random. The unit is configured between
// frames and, when drained, mid-frame.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_obstacle_flag_stencil_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ofs_pkg::*;

  localparam int STORE_DEPTH   = MAX_WIDTH_DEF + 2;
  localparam int RANDOM_PIXELS = 1100;
  // index outside the register map; the unit must ignore a write to it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // one predicted result word
  typedef struct packed {
    ofs_stencil_t      flags;
    logic              forbidden;
    logic [SIZE_W-1:0] col;
    logic [SIZE_W-1:0] row;
    logic              last;
  } cell_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [GREY_W-1:0]    in_grey_level = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [FLAGS_W-1:0]   out_cell_flags;
  logic                 out_forbidden;
  logic [SIZE_W-1:0]    out_cell_col;
  logic [SIZE_W-1:0]    out_cell_row;
  logic                 out_last_cell;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_THRESHOLD;
  logic [SIZE_W-1:0]    cfg_data = '0;

  // predictor state: registers, line stores and raster position
  logic [GREY_W-1:0] thr_reg = THRESHOLD_RST;
  logic [SIZE_W-1:0] width_reg = WIDTH_RST;
  logic [SIZE_W-1:0] height_reg = HEIGHT_RST;
  bit                older_row [STORE_DEPTH];
  bit                middle_row [STORE_DEPTH];
  int                col_pos = 0;
  int                row_pos = 0;
  bit                west_bit = 1'b0;

  cell_word_t pending_cells[$];
  int         fail_count = 0;
  int         pixels_sent = 0;
  bit         gaps_on = 1'b1;
  int         sink_hold_req = 0;

  obstacle_flag_stencil_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_grey_level  (in_grey_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_flags (out_cell_flags),
    .out_forbidden  (out_forbidden),
    .out_cell_col   (out_cell_col),
    .out_cell_row   (out_cell_row),
    .out_last_cell  (out_last_cell),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // generous ceiling: a few times the slowest legal run
  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

  // sizes of 0 act as 1, anything past the store bound acts as the bound
  function automatic int clamp_extent(input logic [SIZE_W-1:0] v, input int top);
    if (v == 0) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  // Advance the predictor by one accepted pixel and queue the cell word that
  // it completes, if any.
  task automatic stencil_predict(input logic [GREY_W-1:0] grey);
    int         w;
    int         h;
    bit         fluid;
    bit         ctr;
    bit         est;
    bit         sth;
    cell_word_t cw;
    w     = clamp_extent(width_reg, MAX_WIDTH_DEF);
    h     = clamp_extent(height_reg, MAX_HEIGHT_DEF);
    fluid = grey > thr_reg;
    ctr   = (col_pos < STORE_DEPTH) ? middle_row[col_pos] : 1'b0;
    est   = (col_pos + 1 < STORE_DEPTH) ? middle_row[col_pos + 1] : 1'b0;
    sth   = (col_pos < STORE_DEPTH) ? older_row[col_pos] : 1'b0;

    // the pixel just in is the north neighbour of the cell one row up
    if (row_pos >= 2 && row_pos <= h + 1 && col_pos >= 1 && col_pos <= w) begin
      cw.flags.center = ctr;
      cw.flags.east   = est;
      cw.flags.west   = west_bit;
      cw.flags.south  = sth;
      cw.flags.north  = fluid;
      if (ctr) begin
        cw.forbidden = (!est && !west_bit) || (!fluid && !sth);
      end else begin
        cw.forbidden = (est && west_bit) || (fluid && sth);
      end
      cw.col  = SIZE_W'(col_pos);
      cw.row  = SIZE_W'(row_pos - 1);
      cw.last = (col_pos == w) && (row_pos == h + 1);
      pending_cells.push_back(cw);
    end

    // shift both line stores at this column
    west_bit = ctr;
    if (col_pos < STORE_DEPTH) begin
      older_row[col_pos]  = ctr;
      middle_row[col_pos] = fluid;
    end

    // advance raster position; a counter past a shrunken end wraps now
    if (col_pos >= w + 1) begin
      col_pos = 0;
      row_pos = (row_pos >= h + 1) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // Offer one pixel word and hold it until accepted. Valid stays high on
  // return so that back-to-back words need no extra edge.
  task automatic send_pixel(input logic [GREY_W-1:0] grey);
    if (gaps_on && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_grey_level <= grey;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
    stencil_predict(grey);
  endtask

  // Write one register. Call only with the unit drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_THRESHOLD: thr_reg = data[GREY_W-1:0];
      CFG_WIDTH:     width_reg = data;
      CFG_HEIGHT:    height_reg = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Drop valid, wait for every predicted word, then let the pipe settle:
  // pixels outside the interior leave no word behind them.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly full-range grey, with a fair share at the extremes and hugging
  // the threshold so that both sides of the compare are hit often.
  function automatic logic [GREY_W-1:0] pick_grey();
    int v;
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3, 4: begin
        v = int'(thr_reg) + $urandom_range(4) - 2;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return GREY_W'(v);
      end
      default: return GREY_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_threshold_data();
    // upper data bits are junk for this register
    case ($urandom_range(9))
      0: return {3'($urandom_range(7)), 8'h00};
      1: return {3'($urandom_range(7)), 8'hff};
      default: return SIZE_W'($urandom_range(2047));
    endcase
  endfunction

  // Send pixels until the raster position is back at the frame origin; from
  // the origin that is one whole frame.
  task automatic stream_to_frame_end();
    do send_pixel(pick_grey()); while (col_pos != 0 || row_pos != 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Two tiny hand-built frames: threshold left at reset (100, 101 fluid),
  // grey extremes, a fluid cell with both vertical neighbours solid, a solid
  // cell with both vertical or both horizontal neighbours fluid, last cell.
  task automatic test_directed_frames();
    logic [GREY_W-1:0] frame_a [9];
    logic [GREY_W-1:0] frame_b [15];
    frame_a = '{8'd100, 8'd101, 8'd100,
                8'd0,   8'd100, 8'd255,
                8'd255, 8'd101, 8'd0};
    frame_b = '{8'd0,   8'd0,   8'd255, 8'd0,  8'd0,
                8'd255, 8'd101, 8'd255, 8'd50, 8'd255,
                8'd0,   8'd0,   8'd255, 8'd0,  8'd0};
    write_reg(CFG_WIDTH, 11'd1);
    write_reg(CFG_HEIGHT, 11'd1);
    foreach (frame_a[i]) send_pixel(frame_a[i]);
    drain_results();
    write_reg(CFG_WIDTH, 11'd3);
    foreach (frame_b[i]) send_pixel(frame_b[i]);
    drain_results();
  endtask

  // Register writes while drained part-way through a frame: shrink the width
  // under the column counter, grow the height, shrink it under the row
  // counter, and poke the unused index.
  task automatic test_midframe_writes();
    write_reg(CFG_THRESHOLD, pick_threshold_data());
    write_reg(CFG_WIDTH, 11'd8);
    write_reg(CFG_HEIGHT, 11'd6);
    repeat ($urandom_range(25, 50)) send_pixel(pick_grey());
    drain_results();
    write_reg(CFG_THRESHOLD, pick_threshold_data());
    write_reg(CFG_WIDTH, SIZE_W'($urandom_range(1, 4)));
    write_reg(CFG_UNUSED, SIZE_W'($urandom_range(2047)));
    stream_to_frame_end();
    drain_results();

    write_reg(CFG_WIDTH, 11'd5);
    write_reg(CFG_HEIGHT, 11'd2);
    repeat (20) send_pixel(pick_grey());
    drain_results();
    write_reg(CFG_HEIGHT, 11'd6);
    stream_to_frame_end();
    drain_results();

    write_reg(CFG_WIDTH, 11'd4);
    // five full rows puts the row counter past a height of one
    repeat (30) send_pixel(pick_grey());
    drain_results();
    write_reg(CFG_HEIGHT, 11'd1);
    stream_to_frame_end();
    drain_results();
  endtask

  // Hold the sink off long enough for the unit to fill and stall its input,
  // then pause the source mid-frame until every word has come out.
  task automatic test_backpressure();
    write_reg(CFG_WIDTH, 11'd10);
    write_reg(CFG_HEIGHT, 11'd10);
    gaps_on = 1'b0;
    sink_hold_req = 300;
    stream_to_frame_end();
    repeat (40) send_pixel(pick_grey());
    drain_results();
    stream_to_frame_end();
    drain_results();
    gaps_on = 1'b1;
  endtask

  // Out-of-range sizes: zeros acting as one, and sizes past the bound written
  // mid-frame, then pulled back so that the counters wrap early.
  task automatic test_size_extremes();
    write_reg(CFG_THRESHOLD, pick_threshold_data());
    write_reg(CFG_WIDTH, 11'd0);
    write_reg(CFG_HEIGHT, 11'd0);
    stream_to_frame_end();
    drain_results();

    // five full rows under a height past the bound, then wrap at row five
    write_reg(CFG_WIDTH, 11'd3);
    write_reg(CFG_HEIGHT, 11'd2047);
    repeat (25) send_pixel(pick_grey());
    drain_results();
    write_reg(CFG_HEIGHT, 11'd2);
    stream_to_frame_end();
    drain_results();

    // stop on the column just past the interior, widen past the bound, then
    // narrow again under the column counter
    write_reg(CFG_THRESHOLD, pick_threshold_data());
    write_reg(CFG_WIDTH, 11'd4);
    write_reg(CFG_HEIGHT, 11'd3);
    repeat (17) send_pixel(pick_grey());
    drain_results();
    write_reg(CFG_WIDTH, 11'd2047);
    repeat (5) send_pixel(pick_grey());
    drain_results();
    write_reg(CFG_WIDTH, 11'd4);
    stream_to_frame_end();
    drain_results();
  endtask

  // Random small frames, back to back in runs of one to three per setting.
  // Idling switches off across the middle of the budget.
  task automatic test_random_frames();
    int start;
    int done;
    start = pixels_sent;
    done  = 0;
    while (done < RANDOM_PIXELS) begin
      drain_results();
      gaps_on = !(done > RANDOM_PIXELS * 2 / 5 && done < RANDOM_PIXELS * 3 / 5);
      if ($urandom_range(2) != 0) write_reg(CFG_THRESHOLD, pick_threshold_data());
      if ($urandom_range(7) == 0) begin
        write_reg(CFG_WIDTH, SIZE_W'($urandom_range(13, 40)));
        write_reg(CFG_HEIGHT, SIZE_W'($urandom_range(1, 6)));
      end else begin
        if ($urandom_range(2) != 0) write_reg(CFG_WIDTH, SIZE_W'($urandom_range(1, 12)));
        if ($urandom_range(2) != 0) write_reg(CFG_HEIGHT, SIZE_W'($urandom_range(1, 8)));
      end
      repeat ($urandom_range(1, 3)) stream_to_frame_end();
      done = pixels_sent - start;
    end
    gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sink: random ready, plus long hold-offs counted here on request
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (sink_hold_req != 0) begin
        stall_left    = sink_hold_req;
        sink_hold_req = 0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (gaps_on && $urandom_range(99) < 37) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check: every accepted word against the oldest prediction
  // --------------------------------------------------------------------------
  task automatic check_cell_word();
    cell_word_t exp_w;
    if (pending_cells.size() == 0) begin
      $error("cell word with none predicted: col %0d row %0d", out_cell_col, out_cell_row);
      fail_count++;
    end else begin
      exp_w = pending_cells.pop_front();
      if (out_cell_flags !== FLAGS_W'(exp_w.flags)) begin
        $error("cell_flags: expected %0d, actual %0d", exp_w.flags, out_cell_flags);
        fail_count++;
      end
      if (out_forbidden !== exp_w.forbidden) begin
        $error("forbidden: expected %0d, actual %0d", exp_w.forbidden, out_forbidden);
        fail_count++;
      end
      if (out_cell_col !== exp_w.col) begin
        $error("cell_col: expected %0d, actual %0d", exp_w.col, out_cell_col);
        fail_count++;
      end
      if (out_cell_row !== exp_w.row) begin
        $error("cell_row: expected %0d, actual %0d", exp_w.row, out_cell_row);
        fail_count++;
      end
      if (out_last_cell !== exp_w.last) begin
        $error("last_cell: expected %0d, actual %0d", exp_w.last, out_last_cell);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_cell_word();
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_midframe_writes();
    test_backpressure();
    test_size_extremes();
    test_random_frames();

    // wait out the last words and the registered pipe behind them
    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_cells.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
